// File: hdl/sle_pkg.sv
// sle_pkg: shared types and constants of the sequential list engine
// used by the cell row and the top level; depends on nothing
package sle_pkg;

  // field widths fixed by the channel format
  localparam int DATA_W  = 32;
  localparam int ACT_W   = 3;
  localparam int POS_W   = 7;
  localparam int FAC_W   = 2;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // action codes of the input word
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_PRED   = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_SCALE  = 3'd6
  } act_t;

  // accepted scale factors
  localparam logic [FAC_W-1:0] FAC_X2 = 2'd2;
  localparam logic [FAC_W-1:0] FAC_X3 = 2'd3;

  // data returned by a failed predecessor lookup
  localparam logic [DATA_W-1:0] PRED_MISS = '1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: hdl/sle_in_if.sv
// sle_in_if: input channel of the sequential list engine
// valid/ready handshake with action, value, position and factor; no dependencies
interface sle_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;
  logic [6:0]         position;
  logic [1:0]         factor;

  modport source (output valid, action, value, position, factor, input ready);
  modport sink   (input valid, action, value, position, factor, output ready);
endinterface

// File: hdl/sle_out_if.sv
// sle_out_if: result channel of the sequential list engine
// valid/ready handshake with the result fields; no dependencies
interface sle_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] data;
  logic [5:0]         index;
  logic [6:0]         count;
  logic               empty_res;
  logic               full_res;

  modport source (output valid, ok, data, index, count, empty_res, full_res, input ready);
  modport sink   (input valid, ok, data, index, count, empty_res, full_res, output ready);
endinterface

// File: hdl/sequential_list_engine.sv
// sequential_list_engine: packed list of signed 32-bit elements in a row of cells
// Channels: in_ch (sink) carries one action word; out_ch (source) returns one
// result word per action. A word moves when valid and ready are both high.
// The list lives in a row of CAPACITY cells; cell 0 is the head. Lookups
// (get, locate, predecessor, delete) and scale rotate the whole row once,
// one cell step per cycle, watching and rewriting the element at the head;
// after CAPACITY steps every element is back in place.
// Words are taken only in the idle state, so a new word waits until the result
// of the previous one has been written to the result register.
// Delete removes the element at the edge that writes its result: every cell
// at or after the position takes its right neighbor.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// the cells are not cleared, only elements below the count are ever read.
// A stalled receiver holds the result register; one new word is still taken
// while a result waits, and its result is written once the register frees up.
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  // controller state
  state_t state_r, state_nxt;

  // latched action word
  act_t              act_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;
  logic [FAC_W-1:0]  fac_r;

  // walk bookkeeping
  logic [IDX_W-1:0]  step_r;
  logic              found_r;
  logic              hit_head_r;
  logic [IDX_W-1:0]  hit_r;
  logic [DATA_W-1:0] pred_r;
  logic [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0] cap_r;

  logic [CNT_W-1:0]  count_r, count_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic [COUNT_W-1:0] cnt_o_r, cnt_o_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;

  // row of cells
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] ring_fb;
  cell_ctl_t         cell_ctl;
  logic [IDX_W-1:0]  cell_sel;

  logic              in_fire;
  logic              slot_free;
  logic              fin_fire;
  logic              walk_last;
  logic              walk_op;
  logic              pos_ok;
  logic [POS_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  pos_idx;
  logic              in_list;
  logic              scale_on;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] head_x2;
  logic [DATA_W-1:0] head_scaled;

  // handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign fin_fire    = (state_r == ST_FIN) && slot_free;
  assign walk_last   = (step_r == LAST_IDX);
  assign walk_op     = (act_t'(in_ch.action) == ACT_DELETE) ||
                       (act_t'(in_ch.action) == ACT_GET) ||
                       (act_t'(in_ch.action) == ACT_LOCATE) ||
                       (act_t'(in_ch.action) == ACT_PRED) ||
                       (act_t'(in_ch.action) == ACT_SCALE);

  // position checks against the current count
  assign pos_ok  = (pos_r != '0) &&
                   ((POS_W + CNT_W)'(pos_r) <= (POS_W + CNT_W)'(count_r));
  assign pos_m1  = pos_r - POS_W'(1);
  assign pos_idx = IDX_W'((POS_W + IDX_W)'(pos_m1));
  assign in_list = (CNT_W + 1)'(step_r) < (CNT_W + 1)'(count_r);

  // head element and the scaled value fed back to the tail
  assign head        = cell_q[0];
  assign head_x2     = {head[DATA_W-2:0], 1'b0};
  assign scale_on    = (act_r == ACT_SCALE) && (fac_r inside {FAC_X2, FAC_X3});
  assign head_scaled = (fac_r == FAC_X3) ? head_x2 + head : head_x2;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = walk_op ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (walk_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell row control
  always_comb begin
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.value = val_r;
    cell_sel       = pos_idx;
    ring_fb        = head;
    case (state_r)
      ST_WALK: begin
        cell_ctl.op = CELL_ROTATE;
        if (scale_on && in_list) ring_fb = head_scaled;
      end
      ST_FIN: begin
        if (slot_free) begin
          if (act_r == ACT_INSERT && count_r != CAP_CNT) begin
            cell_ctl.op = CELL_INSERT;
            cell_sel    = IDX_W'(count_r);
          end else if (act_r == ACT_DELETE && pos_ok) begin
            cell_ctl.op = CELL_DELETE;
            ring_fb     = cell_q[CAPACITY-1];
          end
        end
      end
      default: cell_ctl.op = CELL_HOLD;
    endcase
  end

  // cells, each taking its right neighbor; the tail takes the ring feedback
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr = ring_fb;
    end else begin : g_body
      assign nbr = cell_q[i+1];
    end
    sle_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk    (clk),
      .ctl_i  (cell_ctl),
      .sel_i  (cell_sel),
      .nbr_i  (nbr),
      .data_o (cell_q[i])
    );
  end

  // count and result fields
  always_comb begin
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    data_nxt  = '0;
    index_nxt = '0;
    case (act_r)
      ACT_INSERT: begin
        ok_nxt = (count_r != CAP_CNT);
        if (ok_nxt) count_nxt = count_r + CNT_W'(1);
      end
      ACT_DELETE: begin
        ok_nxt = pos_ok;
        if (pos_ok) begin
          data_nxt  = cap_r;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_GET: begin
        ok_nxt = pos_ok;
        if (pos_ok) data_nxt = cap_r;
      end
      ACT_LOCATE: begin
        ok_nxt = found_r;
        if (found_r) index_nxt = INDEX_W'((IDX_W + INDEX_W)'(hit_r));
      end
      ACT_PRED: begin
        ok_nxt   = found_r && !hit_head_r;
        data_nxt = ok_nxt ? pred_r : PRED_MISS;
      end
      ACT_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      ACT_SCALE: ok_nxt = (fac_r inside {FAC_X2, FAC_X3});
      default:   ok_nxt = 1'b0;
    endcase
    cnt_o_nxt = COUNT_W'((CNT_W + COUNT_W)'(count_nxt));
    empty_nxt = (count_nxt == '0);
    full_nxt  = (count_nxt == CAP_CNT);
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_fire) count_r <= count_nxt;
      if (in_fire) begin
        step_r  <= '0;
        found_r <= 1'b0;
      end else if (state_r == ST_WALK) begin
        step_r <= step_r + IDX_W'(1);
        if (!found_r && in_list && head == val_r) found_r <= 1'b1;
      end
    end
  end

  // latched word and walk captures
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= act_t'(in_ch.action);
      val_r <= in_ch.value;
      pos_r <= in_ch.position;
      fac_r <= in_ch.factor;
    end
    if (state_r == ST_WALK) begin
      prev_r <= head;
      if (step_r == pos_idx) cap_r <= head;
      if (!found_r && in_list && head == val_r) begin
        hit_r      <= step_r;
        hit_head_r <= (step_r == '0);
        pred_r     <= prev_r;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      ok_r    <= ok_nxt;
      data_r  <= data_nxt;
      index_r <= index_nxt;
      cnt_o_r <= cnt_o_nxt;
      empty_r <= empty_nxt;
      full_r  <= full_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = ok_r;
  assign out_ch.data      = data_r;
  assign out_ch.index     = index_r;
  assign out_ch.count     = cnt_o_r;
  assign out_ch.empty_res = empty_r;
  assign out_ch.full_res  = full_r;

  // the list never holds more than the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("list count above capacity");

  // a finished rotation always hands over to the result stage
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && walk_last) |=> (state_r == ST_FIN))
    else $error("walk did not end in result stage");

  // a new result appears only from the result stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside result stage");

  // the count moves only when a result is written
  a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(fin_fire))
    else $error("count changed without a result");

endmodule

// File: hdl/sle_cell.sv
// sle_cell: one element slot of the list row
// takes its right neighbor's element on rotate or delete; depends on sle_pkg
module sle_cell
  import sle_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]  sel_i,
  input  logic [DATA_W-1:0] nbr_i,
  output logic [DATA_W-1:0] data_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // slot update: hold, shift from neighbor or load the inserted element
  always_comb begin
    data_nxt = data_r;
    case (ctl_i.op)
      CELL_ROTATE: data_nxt = nbr_i;
      CELL_INSERT: begin
        if (MY_IDX == sel_i) data_nxt = ctl_i.value;
      end
      CELL_DELETE: begin
        if (MY_IDX >= sel_i) data_nxt = nbr_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
